// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

    // Field and register widths
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;
    localparam int KEY_W    = 64;
    localparam int HASH_W   = 32;
    localparam int SZ_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 32;

    // Register reset values
    localparam logic [SZ_W-1:0]   TABLE_SIZE_RST = 9'd256;
    localparam logic [HASH_W-1:0] HASH_MULT_RST  = 32'd16777619;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MULT  = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_SET = 2'd0,
        REQ_GET = 2'd1,
        REQ_DEL = 2'd2,
        REQ_RSV = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

endpackage

// ===== rtl/lpht_ifs.sv =====
interface lpht_req_if #(
    parameter int VALUE_WIDTH = 64
);
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::REQ_W-1:0]    req_type;
    logic [lpht_pkg::KEY_W-1:0]    key_name;
    logic [VALUE_WIDTH-1:0]        value_in;

    modport source (output valid, req_type, key_name, value_in, input ready);
    modport sink   (input valid, req_type, key_name, value_in, output ready);
endinterface

interface lpht_rsp_if #(
    parameter int VALUE_WIDTH = 64
);
    logic                          valid;
    logic                          ready;
    logic [lpht_pkg::STAT_W-1:0]   status;
    logic [VALUE_WIDTH-1:0]        value_out;

    modport source (output valid, status, value_out, input ready);
    modport sink   (input valid, status, value_out, output ready);
endinterface

// ===== rtl/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/linear_probe_name_hash_table_top.sv =====
// Open-addressing name table with linear probing.
// Requests arrive on i_req (set, get, delete) with an 8-byte name and a value;
// each request gives one transfer on o_rsp carrying a status and, for a
// successful get, the stored value. A slot matches on its 32-bit name hash.
// Configuration (table size, hash multiplier) is written through i_cfg_we,
// i_cfg_idx and i_cfg_data; the user must write it only while the block is idle (not enforced).
// Per request: hashing (one 32x32 multiply per name byte on the shared
// multiplier), the hash modulo table size (one quotient bit per cycle on a shared
// compare-subtract), then for each probed slot a RAM read and a compare, and
// finally posting the result. At least one slot is probed unless the table is
// full or the code is reserved.
// One request is in flight at a time; i_req.ready is high only when idle.
// After reset a clearing pass marks every slot free; no request is taken during
// it. The result sits in an output register; a new request is accepted while it
// waits, but the next result is held back until the receiver takes the previous
// one.
module linear_probe_name_hash_table_top #(
    parameter int SLOTS       = 256,
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lpht_req_if.sink                            i_req,
    lpht_rsp_if.source                          o_rsp,
    input  logic                                i_cfg_we,
    input  logic [lpht_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lpht_pkg::CFG_W-1:0]          i_cfg_data
);
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int CMP_W  = (CNT_W > lpht_pkg::SZ_W) ? CNT_W : lpht_pkg::SZ_W;
    localparam int HW     = lpht_pkg::HASH_W;
    localparam int WORD_W = 1 + HW + VALUE_WIDTH;

    typedef enum logic [6:0] {
        S_CLR  = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_HASH = 7'b0000100,
        S_MOD  = 7'b0001000,
        S_RD   = 7'b0010000,
        S_CHK  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state                       r_state, n_state;
    logic [lpht_pkg::SZ_W-1:0]    r_table_size;
    logic [HW-1:0]                r_mult;
    logic [IDX_W-1:0]             r_clr, n_clr;
    lpht_pkg::t_req               r_req, n_req;
    logic [lpht_pkg::KEY_W-1:0]   r_key, n_key;
    logic [VALUE_WIDTH-1:0]       r_val, n_val;
    logic [lpht_pkg::SZ_W-1:0]    r_size, n_size;
    logic [HW-1:0]                r_h, n_h;
    logic [HW-1:0]                r_sh, n_sh;
    logic [4:0]                   r_step, n_step;
    logic [lpht_pkg::SZ_W-1:0]    r_rem, n_rem;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [lpht_pkg::SZ_W-1:0]    r_n, n_n;
    logic [CNT_W-1:0]             r_count, n_count;
    lpht_pkg::t_status            r_res, n_res;
    logic [VALUE_WIDTH-1:0]       r_rval, n_rval;
    logic                         r_ov, n_ov;
    lpht_pkg::t_status            r_ostat, n_ostat;
    logic [VALUE_WIDTH-1:0]       r_oval, n_oval;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [WORD_W-1:0]            ram_wdata;
    logic [WORD_W-1:0]            ram_rdata;
    logic                         slot_used;
    logic [HW-1:0]                slot_hash;
    logic [VALUE_WIDTH-1:0]       slot_value;
    logic [lpht_pkg::SZ_W-1:0]    size_use;
    logic [lpht_pkg::SZ_W-1:0]    ts_nz;
    logic [lpht_pkg::SZ_W:0]      mod_t;
    logic [2*HW-1:0]              prod;
    logic [IDX_W-1:0]             idx_next;
    logic                         in_xfer;
    logic                         out_free;

    lpht_ram #(.WIDTH(WORD_W), .DEPTH(SLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign slot_used  = ram_rdata[WORD_W-1];
    assign slot_hash  = ram_rdata[VALUE_WIDTH +: HW];
    assign slot_value = ram_rdata[VALUE_WIDTH-1:0];

    // Clamp the configured size to 1..SLOTS
    always_comb begin
        ts_nz    = (r_table_size == '0) ? lpht_pkg::SZ_W'(1) : r_table_size;
        size_use = ts_nz;
        if (32'(ts_nz) > 32'(SLOTS)) begin
            size_use = lpht_pkg::SZ_W'(SLOTS);
        end
    end

    assign prod     = (r_h ^ HW'(r_key[7:0])) * r_mult;
    assign mod_t    = {r_rem, r_sh[HW-1]};
    assign idx_next = (32'(r_idx) + 32'd1 == 32'(r_size)) ? '0 : r_idx + IDX_W'(1);
    assign in_xfer  = i_req.valid && i_req.ready;
    assign out_free = !r_ov || o_rsp.ready;

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.status    = r_ostat;
    assign o_rsp.value_out = r_oval;

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_req     = r_req;
        n_key     = r_key;
        n_val     = r_val;
        n_size    = r_size;
        n_h       = r_h;
        n_sh      = r_sh;
        n_step    = r_step;
        n_rem     = r_rem;
        n_idx     = r_idx;
        n_n       = r_n;
        n_count   = r_count;
        n_res     = r_res;
        n_rval    = r_rval;
        n_ov      = r_ov;
        n_ostat   = r_ostat;
        n_oval    = r_oval;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;

        // Drop the result once the receiver takes it
        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                n_clr     = r_clr + IDX_W'(1);
                if (r_clr == IDX_W'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_req   = lpht_pkg::t_req'(i_req.req_type);
                    n_key   = i_req.key_name;
                    n_val   = i_req.value_in;
                    n_size  = size_use;
                    n_h     = '0;
                    n_step  = '0;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                // Fold one name byte per cycle
                n_h    = prod[HW-1:0];
                n_key  = r_key >> 8;
                n_step = r_step + 5'd1;
                if (r_step == 5'd7) begin
                    n_sh    = prod[HW-1:0];
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // Restoring remainder, one hash bit per cycle
                n_sh  = r_sh << 1;
                n_rem = (mod_t >= {1'b0, r_size}) ?
                        lpht_pkg::SZ_W'(mod_t - {1'b0, r_size}) :
                        lpht_pkg::SZ_W'(mod_t);
                n_step = r_step + 5'd1;
                if (r_step == 5'd31) begin
                    n_idx  = IDX_W'(n_rem);
                    n_n    = '0;
                    n_rval = '0;
                    n_state = S_RD;
                    case (r_req)
                        lpht_pkg::REQ_SET: begin
                            if (CMP_W'(r_count) >= CMP_W'(r_size)) begin
                                n_res   = lpht_pkg::ST_FULL;
                                n_state = S_FIN;
                            end
                        end
                        lpht_pkg::REQ_GET, lpht_pkg::REQ_DEL: begin
                        end
                        default: begin
                            n_res   = lpht_pkg::ST_NOT_FOUND;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_state = S_RD;
                n_idx   = idx_next;
                n_n     = r_n + lpht_pkg::SZ_W'(1);
                if (r_req == lpht_pkg::REQ_SET) begin
                    if (!slot_used) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, r_h, r_val};
                        n_count   = r_count + CNT_W'(1);
                        n_res     = lpht_pkg::ST_OK;
                        n_state   = S_FIN;
                    end else if (n_n == r_size) begin
                        n_res   = lpht_pkg::ST_FULL;
                        n_state = S_FIN;
                    end
                end else begin
                    if (!slot_used) begin
                        n_res   = lpht_pkg::ST_NOT_FOUND;
                        n_state = S_FIN;
                    end else if (slot_hash == r_h) begin
                        n_res   = lpht_pkg::ST_OK;
                        n_state = S_FIN;
                        if (r_req == lpht_pkg::REQ_GET) begin
                            n_rval = slot_value;
                        end else begin
                            ram_we = 1'b1;
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                    end else if (n_n == r_size) begin
                        n_res   = lpht_pkg::ST_NOT_FOUND;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ostat = r_res;
                    n_oval  = r_rval;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_count      <= '0;
            r_ov         <= 1'b0;
            r_table_size <= lpht_pkg::TABLE_SIZE_RST;
            r_mult       <= lpht_pkg::HASH_MULT_RST;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_we && i_cfg_idx == lpht_pkg::CFG_TABLE_SIZE) begin
                r_table_size <= i_cfg_data[lpht_pkg::SZ_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == lpht_pkg::CFG_HASH_MULT) begin
                r_mult <= i_cfg_data[HW-1:0];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_key   <= n_key;
        r_val   <= n_val;
        r_size  <= n_size;
        r_h     <= n_h;
        r_sh    <= n_sh;
        r_step  <= n_step;
        r_rem   <= n_rem;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_res   <= n_res;
        r_rval  <= n_rval;
        r_ostat <= n_ostat;
        r_oval  <= n_oval;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(SLOTS))
        else $error("entry count above slot count");

    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLR || r_state == S_CHK))
        else $error("store written outside clear or probe");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> (r_n < r_size && 32'(r_idx) < 32'(r_size)))
        else $error("probe beyond size in use");

    a_result_posted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> r_ov)
        else $error("finished request did not post a result");
endmodule

// ===== bench/tb_linear_probe_name_hash_table_top.sv =====
module tb_linear_probe_name_hash_table_top;

    localparam int SLOTS       = 256;
    localparam int VALUE_WIDTH = 64;
    localparam int IDLE_LIMIT  = 4000;

    typedef struct packed {
        lpht_pkg::t_req kind;
        logic [63:0]    name;
        logic [63:0]    value;
    } t_request;

    typedef struct packed {
        lpht_pkg::t_status status;
        logic [63:0]       value;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [lpht_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [lpht_pkg::CFG_W-1:0]     i_cfg_data;

    lpht_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
    lpht_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH)) rsp_ch ();

    linear_probe_name_hash_table_top #(.SLOTS(SLOTS), .VALUE_WIDTH(VALUE_WIDTH)) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Table shadow
    logic [8:0]  size_reg;
    logic [31:0] mult_reg;
    logic        used_tab [SLOTS];
    logic [31:0] hash_tab [SLOTS];
    logic [63:0] value_tab[SLOTS];
    int          entries;

    t_request pending_reqs[$];
    t_answer  expected_answers[$];
    int       errors;
    int       req_sent;
    int       rsp_seen;
    int       idle_cycles;
    int       n_ok, n_full, n_miss;
    int       hold_off;
    int       reset_done;
    logic     feed_open;
    logic     req_taken;

    // Clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] name_hash(logic [63:0] name);
        logic [31:0] h;
        h = '0;
        for (int i = 0; i < 8; i++) begin
            h = h ^ {24'd0, name[8*i +: 8]};
            h = h * mult_reg;
        end
        return h;
    endfunction

    function automatic int active_slots();
        if (size_reg == 0) return 1;
        if (size_reg > SLOTS) return SLOTS;
        return int'(size_reg);
    endfunction

    function automatic int locate(logic [31:0] h, int size);
        int idx;
        idx = int'(h % size);
        for (int n = 0; n < size; n++) begin
            if (!used_tab[idx]) return -1;
            if (hash_tab[idx] == h) return idx;
            idx = (idx + 1) % size;
        end
        return -1;
    endfunction

    // Apply one request to the shadow table and return the expected answer
    function automatic t_answer table_lookup(t_request r);
        t_answer     a;
        int          size;
        int          idx;
        logic [31:0] h;
        size = active_slots();
        h = name_hash(r.name);
        a.status = lpht_pkg::ST_NOT_FOUND;
        a.value = '0;
        case (r.kind)
            lpht_pkg::REQ_SET: begin
                a.status = lpht_pkg::ST_FULL;
                if (entries < size) begin
                    idx = int'(h % size);
                    for (int n = 0; n < size; n++) begin
                        if (!used_tab[idx]) begin
                            used_tab[idx] = 1'b1;
                            hash_tab[idx] = h;
                            value_tab[idx] = r.value;
                            entries++;
                            a.status = lpht_pkg::ST_OK;
                            break;
                        end
                        idx = (idx + 1) % size;
                    end
                end
            end
            lpht_pkg::REQ_GET: begin
                idx = locate(h, size);
                if (idx >= 0) begin
                    a.status = lpht_pkg::ST_OK;
                    a.value = value_tab[idx];
                end
            end
            lpht_pkg::REQ_DEL: begin
                idx = locate(h, size);
                if (idx >= 0) begin
                    used_tab[idx] = 1'b0;
                    hash_tab[idx] = '0;
                    value_tab[idx] = '0;
                    if (entries > 0) entries--;
                    a.status = lpht_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on response %0d: %s got %h expected %h", rsp_seen, what, got, want);
        errors++;
    endtask

    // Driver: bursts with gaps; hold an offered transfer until it is taken
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (req_ch.valid && !req_taken) begin
            req_ch.valid <= 1'b1;
        end else begin
            req_taken = 1'b0;
            if (!reset_done || !feed_open || pending_reqs.size() == 0) begin
                req_ch.valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else begin
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= pending_reqs[0].kind;
                req_ch.key_name <= pending_reqs[0].name;
                req_ch.value_in <= pending_reqs[0].value;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                end
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    int stall_phase;
    always @(negedge i_clk) begin
        stall_phase++;
        if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready <= 1'b0;
        end else if (stall_phase % 256 < 64) begin
            rsp_ch.ready <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: predict on each accepted request, check each response
    always @(posedge i_clk) begin
        if (reset_done) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
        if (reset_done && req_ch.valid && req_ch.ready) begin
            expected_answers.push_back(table_lookup(pending_reqs.pop_front()));
            req_sent++;
            req_taken = 1'b1;
        end
        if (reset_done && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected transfer", 64'(rsp_ch.status), 64'd0);
            end else begin
                t_answer want;
                want = expected_answers.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
                if (rsp_ch.value_out !== want.value)
                    report_mismatch("value_out", rsp_ch.value_out, want.value);
                case (want.status)
                    lpht_pkg::ST_OK:   n_ok++;
                    lpht_pkg::ST_FULL: n_full++;
                    default:           n_miss++;
                endcase
            end
            rsp_seen++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d responses outstanding", expected_answers.size());
            $display("linear_probe_name_hash_table_top test failed");
            $finish;
        end
    end

    task automatic push_req(lpht_pkg::t_req k, logic [63:0] n, logic [63:0] v);
        t_request r;
        r.kind = k;
        r.name = n;
        r.value = v;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Feed queued requests, then wait for all answers and the block to settle
    task automatic run_phase();
        feed_open = 1'b1;
        while (pending_reqs.size() != 0 || expected_answers.size() != 0) @(posedge i_clk);
        feed_open = 1'b0;
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lpht_pkg::CFG_IDX_W-1:0] idx,
                             logic [lpht_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lpht_pkg::CFG_TABLE_SIZE) size_reg = data[8:0];
        else mult_reg = data;
    endtask

    // Random phase: names from a small pool so that lookups hit
    task automatic random_phase(int count, int pool_size);
        logic [63:0] pool[];
        int          pick;
        pool = new[pool_size];
        foreach (pool[i]) pool[i] = rand64();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, pool_size - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_req(lpht_pkg::REQ_SET, pool[pick], rand64());
                4, 5, 6:    push_req(lpht_pkg::REQ_GET, pool[pick], rand64());
                7, 8:       push_req(lpht_pkg::REQ_DEL, pool[pick], rand64());
                default:    push_req(lpht_pkg::t_req'(2'($urandom_range(0, 3))),
                                     rand64(), rand64());
            endcase
        end
        run_phase();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.key_name = '0;
        req_ch.value_in = '0;
        rsp_ch.ready = 1'b0;
        size_reg = lpht_pkg::TABLE_SIZE_RST;
        mult_reg = lpht_pkg::HASH_MULT_RST;
        foreach (used_tab[i]) begin
            used_tab[i] = 1'b0;
            hash_tab[i] = '0;
            value_tab[i] = '0;
        end
        entries = 0; errors = 0; req_sent = 0; rsp_seen = 0; idle_cycles = 0;
        n_ok = 0; n_full = 0; n_miss = 0; hold_off = 0; reset_done = 0;
        feed_open = 1'b0; burst_left = 0; gap_left = 0; stall_phase = 0;
        req_taken = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // allow for the clearing pass after reset
        repeat (SLOTS + 20) @(posedge i_clk);
        reset_done = 1;

        // Directed: extremes, every request, reserved code, misses on an empty table
        push_req(lpht_pkg::REQ_GET, 64'h0, 64'h0);
        push_req(lpht_pkg::REQ_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        push_req(lpht_pkg::REQ_SET, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(lpht_pkg::REQ_SET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        push_req(lpht_pkg::REQ_SET, 64'h0, 64'h1234_5678_9ABC_DEF0);
        push_req(lpht_pkg::REQ_GET, 64'h0, 64'h0);
        push_req(lpht_pkg::REQ_GET, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        push_req(lpht_pkg::REQ_RSV, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        push_req(lpht_pkg::REQ_DEL, 64'h0, 64'h0);
        push_req(lpht_pkg::REQ_GET, 64'h0, 64'h0);
        push_req(lpht_pkg::REQ_DEL, 64'h0, 64'h0);
        push_req(lpht_pkg::REQ_DEL, 64'h0, 64'h0);
        push_req(lpht_pkg::REQ_GET, 64'hA5A5_5A5A_0F0F_F0F0, 64'h0);
        run_phase();

        // Smallest table, then size zero: table-full and the wrap limit
        write_reg(lpht_pkg::CFG_TABLE_SIZE, 32'd1);
        push_req(lpht_pkg::REQ_SET, 64'h55, 64'h1);
        push_req(lpht_pkg::REQ_SET, 64'h66, 64'h2);
        push_req(lpht_pkg::REQ_GET, 64'h66, 64'h0);
        push_req(lpht_pkg::REQ_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        push_req(lpht_pkg::REQ_DEL, 64'h0, 64'h0);
        run_phase();
        write_reg(lpht_pkg::CFG_TABLE_SIZE, 32'd0);
        write_reg(lpht_pkg::CFG_HASH_MULT, 32'd0);
        push_req(lpht_pkg::REQ_SET, 64'h77, 64'h3);
        push_req(lpht_pkg::REQ_GET, 64'h88, 64'h0);
        push_req(lpht_pkg::REQ_DEL, 64'h99, 64'h0);
        push_req(lpht_pkg::REQ_SET, 64'h1, 64'h4);
        run_phase();

        // Oversize table acts as the full store; stale entries remain counted
        write_reg(lpht_pkg::CFG_TABLE_SIZE, 32'd511);
        write_reg(lpht_pkg::CFG_HASH_MULT, 32'hFFFF_FFFF);
        random_phase(120, 40);

        // Long receiver hold-off while requests keep coming
        write_reg(lpht_pkg::CFG_TABLE_SIZE, 32'd8);
        write_reg(lpht_pkg::CFG_HASH_MULT, 32'd16777619);
        hold_off = 600;
        random_phase(150, 12);

        write_reg(lpht_pkg::CFG_TABLE_SIZE, 32'd3);
        write_reg(lpht_pkg::CFG_HASH_MULT, 32'd1);
        random_phase(100, 6);

        write_reg(lpht_pkg::CFG_TABLE_SIZE, 32'd256);
        write_reg(lpht_pkg::CFG_HASH_MULT, $urandom());
        random_phase(230, 60);

        $display("requests %0d, responses %0d: ok %0d, full %0d, not found %0d",
                 req_sent, rsp_seen, n_ok, n_full, n_miss);
        $display("sizes 0/1/3/8/256/511 and multipliers 0/1/max/random covered");
        if (errors == 0) begin
            $display("linear_probe_name_hash_table_top test passed");
        end else begin
            $display("linear_probe_name_hash_table_top test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_ifs.sv
rtl/lpht_ram.sv
rtl/linear_probe_name_hash_table_top.sv
bench/tb_linear_probe_name_hash_table_top.sv
